[hdl/fmmp_pkg.sv]
package fmmp_pkg;

  localparam int INDEX_BITS_DEFAULT = 63;
  localparam int VALUE_W = 30;

  localparam logic [VALUE_W-1:0] PRIME = 30'd1000000007;

  // Barrett reduction of a product below 2^60: q = ((x >> 29) * M) >> 31.
  localparam int BARRETT_PRE = 29;
  localparam int BARRETT_POST = 31;
  localparam longint unsigned BARRETT_FULL = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_M = BARRETT_FULL[30:0];

  typedef enum logic [1:0] {
    PH_MUL  = 2'd0,
    PH_EST  = 2'd1,
    PH_QP   = 2'd2,
    PH_FOLD = 2'd3
  } phase_t;

  typedef struct packed {
    logic       init;
    logic       mul_en;
    phase_t     phase;
    logic [1:0] entry;
    logic       term;
    logic       commit;
    logic       qstep;
    logic       shift;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic e_msb;
  } status_t;

endpackage

[hdl/fmmp_ctrl.sv]
module fmmp_ctrl #(
  parameter int INDEX_BITS = fmmp_pkg::INDEX_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  fmmp_pkg::status_t status,
  output fmmp_pkg::cmd_t    cmd
);

  localparam int CNT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQ     = 6'b000010,
    S_COMMIT = 6'b000100,
    S_QMUL   = 6'b001000,
    S_BIT    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t           state, state_next;
  fmmp_pkg::phase_t ph, ph_next;
  logic             term, term_next;
  logic [1:0]       entry, entry_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid;

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    ph_next    = ph;
    term_next  = term;
    entry_next = entry;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.phase  = ph;
    cmd.entry  = entry;
    cmd.term   = term;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.init   = 1'b1;
          ph_next    = fmmp_pkg::PH_MUL;
          term_next  = 1'b0;
          entry_next = 2'd0;
          cnt_next   = CNT_W'(INDEX_BITS - 1);
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        case (ph)
          fmmp_pkg::PH_MUL:  ph_next = fmmp_pkg::PH_EST;
          fmmp_pkg::PH_EST:  ph_next = fmmp_pkg::PH_QP;
          fmmp_pkg::PH_QP:   ph_next = fmmp_pkg::PH_FOLD;
          default:           ph_next = fmmp_pkg::PH_MUL;
        endcase
        if (ph == fmmp_pkg::PH_FOLD) begin
          if (term) begin
            term_next  = 1'b0;
            entry_next = entry + 2'd1;
            if (&entry) begin
              state_next = S_COMMIT;
            end
          end else begin
            term_next = 1'b1;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = status.e_msb ? S_QMUL : S_BIT;
      end
      S_QMUL: begin
        cmd.qstep  = 1'b1;
        state_next = S_BIT;
      end
      S_BIT: begin
        cmd.shift = 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end else begin
          cnt_next   = cnt - CNT_W'(1);
          state_next = S_SQ;
        end
      end
      S_DONE: begin
        if (!out_valid || !rsp_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= fmmp_pkg::PH_MUL;
      term      <= 1'b0;
      entry     <= 2'd0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      term  <= term_next;
      entry <= entry_next;
      cnt   <= cnt_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/fmmp_datapath.sv]
module fmmp_datapath #(
  parameter int INDEX_BITS = fmmp_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic [INDEX_BITS-1:0]         index,
  input  fmmp_pkg::cmd_t                cmd,
  output fmmp_pkg::status_t             status,
  output logic [fmmp_pkg::VALUE_W-1:0]  fib_value
);

  localparam int W = fmmp_pkg::VALUE_W;

  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    begin
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, fmmp_pkg::PRIME}) begin
        s = s - {1'b0, fmmp_pkg::PRIME};
      end
      return s[W-1:0];
    end
  endfunction

  logic [W-1:0]          ma, mb, mc, md;
  logic [W-1:0]          na, nb, nc, nd;
  logic [W-1:0]          acc;
  logic [INDEX_BITS-1:0] e_reg;
  logic                  zero;
  logic [59:0]           x_reg;
  logic [30:0]           q_reg;
  logic [60:0]           qp_reg;

  logic [W-1:0]  op_a, op_b;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [31:0]   diff, fix1, fix2;
  logic [W-1:0]  rem, total;

  assign status.e_msb = e_reg[INDEX_BITS-1];

  always_comb begin
    if (cmd.entry[1]) begin
      op_a = cmd.term ? md : mc;
    end else begin
      op_a = cmd.term ? mb : ma;
    end
    if (cmd.term) begin
      op_b = cmd.entry[0] ? md : mc;
    end else begin
      op_b = cmd.entry[0] ? mb : ma;
    end
  end

  always_comb begin
    case (cmd.phase)
      fmmp_pkg::PH_MUL: begin
        mul_a = {2'b00, op_a};
        mul_b = {2'b00, op_b};
      end
      fmmp_pkg::PH_EST: begin
        mul_a = {1'b0, x_reg[59:fmmp_pkg::BARRETT_PRE]};
        mul_b = {1'b0, fmmp_pkg::BARRETT_M};
      end
      fmmp_pkg::PH_QP: begin
        mul_a = {1'b0, q_reg};
        mul_b = {2'b00, fmmp_pkg::PRIME};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // The Barrett estimate is short by at most two, so the remainder stays below 3p.
  always_comb begin
    diff  = x_reg[31:0] - qp_reg[31:0];
    fix1  = (diff >= {2'b00, fmmp_pkg::PRIME}) ? diff - {2'b00, fmmp_pkg::PRIME} : diff;
    fix2  = (fix1 >= {2'b00, fmmp_pkg::PRIME}) ? fix1 - {2'b00, fmmp_pkg::PRIME} : fix1;
    rem   = fix2[W-1:0];
    total = mod_add(acc, rem);
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      ma    <= W'(1);
      mb    <= '0;
      mc    <= '0;
      md    <= W'(1);
      e_reg <= index - INDEX_BITS'(1);
      zero  <= (index == '0);
    end
    if (cmd.mul_en) begin
      case (cmd.phase)
        fmmp_pkg::PH_MUL: x_reg  <= prod[59:0];
        fmmp_pkg::PH_EST: q_reg  <= prod[61:fmmp_pkg::BARRETT_POST];
        fmmp_pkg::PH_QP:  qp_reg <= prod[60:0];
        default: begin
          if (!cmd.term) begin
            acc <= rem;
          end else begin
            case (cmd.entry)
              2'd0:    na <= total;
              2'd1:    nb <= total;
              2'd2:    nc <= total;
              default: nd <= total;
            endcase
          end
        end
      endcase
    end
    if (cmd.commit) begin
      ma <= na;
      mb <= nb;
      mc <= nc;
      md <= nd;
    end
    if (cmd.qstep) begin
      ma <= mod_add(ma, mb);
      mb <= ma;
      mc <= mod_add(mc, md);
      md <= mc;
    end
    if (cmd.shift) begin
      e_reg <= e_reg << 1;
    end
    if (cmd.emit) begin
      fib_value <= zero ? '0 : ma;
    end
  end

endmodule

[hdl/fibonacci_mod_matrix_power.sv]
// Channel   Handshake             Payload
// request   req_valid, req_stall  index      (INDEX_BITS, unsigned)
// response  rsp_valid, rsp_stall  fib_value  (30 bits, unsigned)
//
// Each item squares once per bit of index-1, MSB first, with a base step at each set bit.
// All products share the single 32x32 multiplier, in phases MUL, EST, QP and FOLD.
// Each squaring needs eight products; a step by the base matrix needs only adds.
// Reset is synchronous and clears the controller; the datapath needs no reset.
// A new item is taken while a finished result waits under rsp_stall.
module fibonacci_mod_matrix_power #(
  parameter int INDEX_BITS = fmmp_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [INDEX_BITS-1:0]        index,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [fmmp_pkg::VALUE_W-1:0] fib_value
);

  fmmp_pkg::cmd_t    cmd;
  fmmp_pkg::status_t status;

  fmmp_ctrl #(
    .INDEX_BITS(INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fmmp_datapath #(
    .INDEX_BITS(INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .index     (index),
    .cmd       (cmd),
    .status    (status),
    .fib_value (fib_value)
  );

endmodule

[hdl/fmmp_checker.sv]
module fmmp_checker #(
  parameter int INDEX_BITS = fmmp_pkg::INDEX_BITS_DEFAULT
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic [INDEX_BITS-1:0]        index,
  input logic                         rsp_valid,
  input logic                         rsp_stall,
  input logic [fmmp_pkg::VALUE_W-1:0] fib_value
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(fib_value))
    else $error("Stalled result item changed or was dropped.");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fib_value < fmmp_pkg::PRIME)
    else $error("Result item is not reduced below the prime.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Block took a second item before finishing the first.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("Result item appeared without an item in progress.");

endmodule

bind fibonacci_mod_matrix_power fmmp_checker #(.INDEX_BITS(INDEX_BITS)) u_fmmp_checker (.*);

[sim/fibonacci_mod_matrix_power_test.sv]
`timescale 1ns / 1ps

module fibonacci_mod_matrix_power_test;

  localparam int INDEX_W = fmmp_pkg::INDEX_BITS_DEFAULT;
  localparam int VALUE_W = fmmp_pkg::VALUE_W;
  localparam logic [63:0] FIB_PRIME = 64'(fmmp_pkg::PRIME);
  localparam int HOLD_CYCLES = 8000;
  localparam int DRAIN_CYCLES = 2 + 35 * INDEX_W + 100;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int NUM_DIRECTED = 22;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic               known;
    logic [VALUE_W-1:0] value;
  } fib_row_t;

  localparam fib_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{63'd0, 1'b1, 30'd0},
    '{63'd1, 1'b1, 30'd1},
    '{63'd2, 1'b1, 30'd1},
    '{63'd3, 1'b1, 30'd2},
    '{63'd4, 1'b1, 30'd3},
    '{63'd5, 1'b1, 30'd5},
    '{63'd10, 1'b1, 30'd55},
    '{63'd40, 1'b1, 30'd102334155},
    '{63'd45, 1'b0, 30'd0},
    '{63'd100, 1'b0, 30'd0},
    '{63'h7FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
    '{63'h7FFF_FFFF_FFFF_FFFE, 1'b0, 30'd0},
    '{63'h4000_0000_0000_0000, 1'b0, 30'd0},
    '{63'h4000_0000_0000_0001, 1'b0, 30'd0},
    '{63'h3FFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
    '{63'h5555_5555_5555_5555, 1'b0, 30'd0},
    '{63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 30'd0},
    '{63'h0000_0001_0000_0000, 1'b0, 30'd0},
    '{63'h0000_0000_FFFF_FFFF, 1'b0, 30'd0},
    '{63'd1000000008, 1'b0, 30'd0},
    '{63'd2000000016, 1'b0, 30'd0},
    '{63'd2000000017, 1'b0, 30'd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [INDEX_W-1:0] index = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [VALUE_W-1:0] fib_value;

  logic [VALUE_W-1:0] expected_fib [$];
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_req = 1'b0;
  bit                 hold_seen = 1'b0;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;

  fibonacci_mod_matrix_power dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .index     (index),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .fib_value (fib_value)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y);
    return (x * y) % FIB_PRIME;
  endfunction

  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y);
    return (x + y) % FIB_PRIME;
  endfunction

  // Square-and-multiply of [[1,1],[1,0]] over the bits of n-1, most significant first.
  function automatic logic [VALUE_W-1:0] fib_mod(input logic [INDEX_W-1:0] n);
    logic [63:0]        a, b, c, d;
    logic [63:0]        ta, tb, tc, td;
    logic [INDEX_W-1:0] e;
    if (n == '0) return '0;
    e = n - 1'b1;
    a = 64'd1;
    b = 64'd0;
    c = 64'd0;
    d = 64'd1;
    for (int i = INDEX_W - 1; i >= 0; i--) begin
      ta = add_mod(mul_mod(a, a), mul_mod(b, c));
      tb = add_mod(mul_mod(a, b), mul_mod(b, d));
      tc = add_mod(mul_mod(c, a), mul_mod(d, c));
      td = add_mod(mul_mod(c, b), mul_mod(d, d));
      a = ta;
      b = tb;
      c = tc;
      d = td;
      if (e[i]) begin
        ta = add_mod(a, b);
        tc = add_mod(c, d);
        b = a;
        d = c;
        a = ta;
        c = tc;
      end
    end
    return a[VALUE_W-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] random_index();
    logic [63:0]        raw;
    logic [INDEX_W-1:0] v;
    int                 kind;
    kind = $urandom_range(0, 9);
    raw = {$urandom, $urandom};
    v = raw[INDEX_W-1:0];
    case (kind)
      6: begin
        v = INDEX_W'($urandom_range(0, 100));
      end
      7: begin
        v = (INDEX_W'(1) << $urandom_range(0, INDEX_W - 1)) + INDEX_W'($urandom_range(0, 2)) -
            INDEX_W'(1);
      end
      8: begin
        v = ~(INDEX_W'(1) << $urandom_range(0, INDEX_W - 1));
      end
      9: begin
        v = INDEX_W'($urandom);
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_index(input logic [INDEX_W-1:0] v, input logic known,
                            input logic [VALUE_W-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    index <= v;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    expected_fib.push_back(known ? value : fib_mod(v));
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_index(random_index(), 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_fib.size() == 0) begin
        $display("%0t: unexpected fib_value result, actual %0d", $time, fib_value);
        mismatch_count++;
      end else begin
        if (fib_value !== expected_fib[0]) begin
          $display("%0t: fib_value mismatch, expected %0d, actual %0d", $time,
                   expected_fib[0], fib_value);
          mismatch_count++;
        end
        void'(expected_fib.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fibonacci_mod_matrix_power_test: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_index(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].value);
    end
    send_random(400);

    send_idle_pct = 60;
    recv_stall_pct = 0;
    send_random(300);

    send_idle_pct = 0;
    recv_stall_pct = 60;
    send_random(300);

    send_idle_pct = 24;
    recv_stall_pct = 24;
    send_random(300);

    // The receiver holds off while items keep coming, so the input side backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = ~hold_req;
    send_random(30);

    send_random(200);

    req_valid <= 1'b0;
    while (expected_fib.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("fibonacci_mod_matrix_power_test: PASS");
    end else begin
      $display("fibonacci_mod_matrix_power_test: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/fmmp_pkg.sv
hdl/fmmp_ctrl.sv
hdl/fmmp_datapath.sv
hdl/fibonacci_mod_matrix_power.sv
hdl/fmmp_checker.sv
sim/fibonacci_mod_matrix_power_test.sv
